FILE: design/assert_macros.svh
// Assertion shorthands for the eight-bit ALU flag unit.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define Z80A_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define Z80A_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/z80alu_pkg.sv
// Shared types and constants for the eight-bit ALU flag unit.
// No dependencies; imported by z80alu_core and eight_bit_alu_flag_unit.
package z80alu_pkg;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0,
    OP_ADC = 5'd1,
    OP_SUB = 5'd2,
    OP_SBC = 5'd3,
    OP_AND = 5'd4,
    OP_XOR = 5'd5,
    OP_OR  = 5'd6,
    OP_CP  = 5'd7,
    OP_INC = 5'd8,
    OP_DEC = 5'd9,
    OP_RLC = 5'd10,
    OP_RRC = 5'd11,
    OP_RL  = 5'd12,
    OP_RR  = 5'd13,
    OP_SLA = 5'd14,
    OP_SRA = 5'd15,
    OP_SLL = 5'd16,
    OP_SRL = 5'd17,
    OP_DAA = 5'd18
  } alu_op_e;

  // Flag byte bit positions.
  localparam int unsigned FLAG_C  = 0;
  localparam int unsigned FLAG_N  = 1;
  localparam int unsigned FLAG_PV = 2;
  localparam int unsigned FLAG_3  = 3;
  localparam int unsigned FLAG_H  = 4;
  localparam int unsigned FLAG_5  = 5;
  localparam int unsigned FLAG_Z  = 6;
  localparam int unsigned FLAG_S  = 7;

  // Decimal adjust constants.
  localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
  localparam logic [7:0] DAA_HI_CORR  = 8'h60;
  localparam logic [7:0] DAA_LO_CORR  = 8'h06;
  localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
  localparam logic [3:0] DAA_LO_HALF  = 4'h5;

  typedef struct packed {
    logic [4:0] opcode;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
    logic       carry_in;
    logic       half_in;
    logic       subtract_in;
  } alu_in_t;

  typedef struct packed {
    logic [7:0] result;
    logic [7:0] flags;
  } alu_out_t;

endpackage

FILE: design/z80alu_core.sv
// Combinational datapath: result byte and flag byte for one operation.
// Depends on z80alu_pkg.
module z80alu_core (
  input  z80alu_pkg::alu_in_t  op_i,
  output z80alu_pkg::alu_out_t res_o
);
  import z80alu_pkg::*;

  logic [7:0] a, b, r, f;
  logic       c;
  logic [8:0] sum9, diff9, s9;
  logic [7:0] x;
  logic       cy;
  logic       bit_out;
  logic [7:0] corr;
  logic       daa_c, daa_h;

  always_comb begin
    a = op_i.operand_a;
    b = op_i.operand_b;
    c = op_i.carry_in;

    // Shared adder and subtractor; carry only for the with-carry forms.
    sum9  = {1'b0, a} + {1'b0, b} + {8'b0, (op_i.opcode == OP_ADC) & c};
    diff9 = {1'b0, a} - {1'b0, b} - {8'b0, (op_i.opcode == OP_SBC) & c};
    s9    = (op_i.opcode == OP_ADD || op_i.opcode == OP_ADC) ? sum9 : diff9;
    x     = s9[7:0] ^ a ^ b;
    cy    = s9[8];

    // Decimal adjust correction.
    corr  = 8'h00;
    daa_c = c;
    if ((a[3:0] > DAA_LO_LIMIT) || op_i.half_in) begin
      corr = corr | DAA_LO_CORR;
    end
    if ((a > DAA_HI_LIMIT) || c) begin
      corr  = corr | DAA_HI_CORR;
      daa_c = 1'b1;
    end
    daa_h = op_i.subtract_in ? (op_i.half_in && (a[3:0] <= DAA_LO_HALF))
                             : (a[3:0] > DAA_LO_LIMIT);

    r       = a;
    bit_out = 1'b0;
    case (op_i.opcode)
      OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_CP: r = s9[7:0];
      OP_AND: r = a & b;
      OP_XOR: r = a ^ b;
      OP_OR:  r = a | b;
      OP_INC: r = a + 8'd1;
      OP_DEC: r = a - 8'd1;
      OP_RLC: begin r = {a[6:0], a[7]}; bit_out = a[7]; end
      OP_RRC: begin r = {a[0], a[7:1]}; bit_out = a[0]; end
      OP_RL:  begin r = {a[6:0], c};    bit_out = a[7]; end
      OP_RR:  begin r = {c, a[7:1]};    bit_out = a[0]; end
      OP_SLA: begin r = {a[6:0], 1'b0}; bit_out = a[7]; end
      OP_SRA: begin r = {a[7], a[7:1]}; bit_out = a[0]; end
      OP_SLL: begin r = {a[6:0], 1'b1}; bit_out = a[7]; end
      OP_SRL: begin r = {1'b0, a[7:1]}; bit_out = a[0]; end
      OP_DAA: r = op_i.subtract_in ? (a - corr) : (a + corr);
      default: r = a;
    endcase

    // Common sign, zero, copy bits and parity; override per class below.
    f          = 8'h00;
    f[FLAG_S]  = r[7];
    f[FLAG_Z]  = (r == 8'h00);
    f[FLAG_5]  = r[5];
    f[FLAG_3]  = r[3];
    f[FLAG_PV] = ~^r;
    case (op_i.opcode)
      OP_ADD, OP_ADC: begin
        f[FLAG_H]  = x[4];
        f[FLAG_PV] = x[7] ^ cy;
        f[FLAG_C]  = cy;
      end
      OP_SUB, OP_SBC: begin
        f[FLAG_H]  = x[4];
        f[FLAG_PV] = x[7] ^ cy;
        f[FLAG_C]  = cy;
        f[FLAG_N]  = 1'b1;
      end
      OP_CP: begin
        // Copy bits come from the operand, not the difference.
        f[FLAG_5]  = b[5];
        f[FLAG_3]  = b[3];
        f[FLAG_H]  = x[4];
        f[FLAG_PV] = x[7] ^ cy;
        f[FLAG_C]  = cy;
        f[FLAG_N]  = 1'b1;
      end
      OP_AND: f[FLAG_H] = 1'b1;
      OP_XOR, OP_OR: f[FLAG_H] = 1'b0;
      OP_INC: begin
        f[FLAG_H]  = r[4] ^ a[4];
        f[FLAG_PV] = (r == 8'h80);
      end
      OP_DEC: begin
        f[FLAG_H]  = r[4] ^ a[4];
        f[FLAG_PV] = (r == 8'h7F);
        f[FLAG_N]  = 1'b1;
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SLL, OP_SRL:
        f[FLAG_C] = bit_out;
      OP_DAA: begin
        f[FLAG_H] = daa_h;
        f[FLAG_N] = op_i.subtract_in;
        f[FLAG_C] = daa_c;
      end
      default: f = 8'h00;
    endcase

    res_o.result = r;
    res_o.flags  = f;
  end

endmodule

FILE: design/eight_bit_alu_flag_unit.sv
// Top level of the eight-bit ALU flag unit: input register, datapath, result register.
// Depends on z80alu_pkg, z80alu_core and assert_macros.svh.
//
//   Channel   Direction  Transfer when          Payload
//   command   in         start_i && !busy_o     data_i  (alu_in_t)
//   result    out        done_o (one cycle)     data_o  (alu_out_t)
//
// A command transferred at a clock edge is registered in in_q, run through the
// datapath in the next cycle and registered again in out_q; done_o and data_o
// hold the result for one cycle after that, and the result transfers at the
// edge that ends that cycle.
// One command is taken every cycle; busy_o stays low, the rate being set by
// the single register-to-register pass through the datapath.
// rst_ni clears both valid bits asynchronously; payload registers are not reset.
// The receiver cannot stall, so nothing is ever held back.
module eight_bit_alu_flag_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  z80alu_pkg::alu_in_t   data_i,
  output logic                  done_o,
  output z80alu_pkg::alu_out_t  data_o
);
  import z80alu_pkg::*;
`include "assert_macros.svh"

  logic     in_valid_q, in_valid_d;
  alu_in_t  in_q;
  logic     out_valid_q, out_valid_d;
  alu_out_t out_q;
  alu_out_t core_res;
  logic     accept;
  logic     zero_flag_ok;

  // Never back-pressure: the pipe advances every cycle.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign in_valid_d  = accept;
  assign out_valid_d = in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the command and the finished result; payload only.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= data_i;
    end
    if (in_valid_q) begin
      out_q <= core_res;
    end
  end

  z80alu_core u_core (
    .op_i  (in_q),
    .res_o (core_res)
  );

  assign done_o = out_valid_q;
  assign data_o = out_q;

  // Zero flag tracks the result byte, except for unused opcodes that clear all flags.
  assign zero_flag_ok = (data_o.flags[FLAG_Z] == (data_o.result == 8'h00)) ||
                        (data_o.flags == 8'h00);

  `Z80A_ASSERT_NEXT(a_accept_to_stage, accept, in_valid_q, "accepted command not staged")
  `Z80A_ASSERT_NEXT(a_stage_to_done, in_valid_q, done_o, "staged command produced no result")
  `Z80A_ASSERT_NOW(a_done_has_cmd, done_o, $past(in_valid_q), "result without a command")
  `Z80A_ASSERT_NOW(a_zero_flag, done_o, zero_flag_ok, "zero flag disagrees with result")

endmodule

FILE: tb/tb_eight_bit_alu_flag_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the eight-bit ALU flag unit: directed table, then random commands.
// Depends on z80alu_pkg and the eight_bit_alu_flag_unit RTL; needs no files or arguments.
module tb_eight_bit_alu_flag_unit;
  import z80alu_pkg::*;

  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned ITEM_COUNT   = 1800;
  localparam int unsigned STALL_LIMIT  = 200;   // cycles with no transfer at all
  localparam int unsigned SETTLE_CYCLES = 4;    // margin after draining, beyond the result latency
  localparam int unsigned MAX_GAP      = 20;
  localparam int unsigned MAX_BURST    = 64;
  localparam logic [4:0]  OP_UNUSED_LO = 5'd19;
  localparam logic [4:0]  OP_UNUSED_HI = 5'd31;

  // Operand values that sit on carry, overflow, nibble and BCD boundaries.
  localparam logic [7:0] CORNER_BYTES [8] = '{8'h00, 8'hFF, 8'h7F, 8'h80,
                                               8'h0F, 8'h10, 8'h99, 8'h9A};

  typedef struct {
    alu_in_t  cmd;
    bit       fixed;   // expectation typed into the table
    alu_out_t want;
  } table_row_t;

  logic     clk_i   = 1'b0;
  logic     rst_ni  = 1'b0;
  logic     start_i = 1'b0;
  alu_in_t  data_i  = '0;
  logic     busy_o;
  logic     done_o;
  alu_out_t data_o;

  // Side channel travelling with data_i: a typed expectation for this command.
  bit       fixed_want_valid = 1'b0;
  alu_out_t fixed_want       = '0;

  alu_out_t    pending_alu_q [$];
  table_row_t  stim_table [$];
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles  = 0;
  int unsigned burst_left   = 0;

  eight_bit_alu_flag_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .data_i (data_i),
    .done_o (done_o),
    .data_o (data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Flag predictor
  // ---------------------------------------------------------------------------

  // Sign, zero and the two undocumented bits copied from the result.
  function automatic logic [7:0] sz53_bits(logic [7:0] r);
    logic [7:0] f;
    f          = '0;
    f[FLAG_S]  = r[7];
    f[FLAG_5]  = r[5];
    f[FLAG_3]  = r[3];
    f[FLAG_Z]  = (r == 8'h00);
    return f;
  endfunction

  // Logic, rotate and shift flavor: P/V is parity, set on an even count of ones.
  function automatic logic [7:0] parity_bits(logic [7:0] r);
    logic [7:0] f;
    f          = sz53_bits(r);
    f[FLAG_PV] = ~^r;
    return f;
  endfunction

  function automatic alu_out_t predict_alu_out(alu_in_t cmd);
    logic [7:0] a, b, r, f, x, corr;
    logic [8:0] sum;
    logic [3:0] lo;
    logic       hf, cf;
    alu_out_t   res;
    a = cmd.operand_a;
    b = cmd.operand_b;
    r = a;
    f = '0;
    case (cmd.opcode)
      OP_ADD, OP_ADC: begin
        sum = {1'b0, a} + {1'b0, b} +
              ((cmd.opcode == OP_ADC) ? {8'd0, cmd.carry_in} : 9'd0);
        r = sum[7:0];
        x = r ^ a ^ b;
        f = sz53_bits(r);
        f[FLAG_H]  = x[4];
        f[FLAG_PV] = x[7] ^ sum[8];
        f[FLAG_C]  = sum[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        sum = {1'b0, a} - {1'b0, b} -
              ((cmd.opcode == OP_SBC) ? {8'd0, cmd.carry_in} : 9'd0);
        r = sum[7:0];
        x = r ^ a ^ b;
        if (cmd.opcode == OP_CP) begin
          // Compare copies bits 5 and 3 from the operand, not the difference.
          f         = '0;
          f[FLAG_S] = r[7];
          f[FLAG_5] = b[5];
          f[FLAG_3] = b[3];
          f[FLAG_Z] = (r == 8'h00);
        end else begin
          f = sz53_bits(r);
        end
        f[FLAG_H]  = x[4];
        f[FLAG_PV] = x[7] ^ sum[8];
        f[FLAG_C]  = sum[8];
        f[FLAG_N]  = 1'b1;
      end
      OP_AND: begin
        r = a & b;
        f = parity_bits(r);
        f[FLAG_H] = 1'b1;
      end
      OP_XOR: begin
        r = a ^ b;
        f = parity_bits(r);
      end
      OP_OR: begin
        r = a | b;
        f = parity_bits(r);
      end
      OP_INC: begin
        r = a + 8'd1;
        f = sz53_bits(r);
        f[FLAG_H]  = r[4] ^ a[4];
        f[FLAG_PV] = (r == 8'h80);
      end
      OP_DEC: begin
        r = a - 8'd1;
        f = sz53_bits(r);
        f[FLAG_H]  = r[4] ^ a[4];
        f[FLAG_PV] = (r == 8'h7F);
        f[FLAG_N]  = 1'b1;
      end
      OP_RLC: begin
        r = {a[6:0], a[7]};
        f = parity_bits(r);
        f[FLAG_C] = a[7];
      end
      OP_RRC: begin
        r = {a[0], a[7:1]};
        f = parity_bits(r);
        f[FLAG_C] = a[0];
      end
      OP_RL: begin
        r = {a[6:0], cmd.carry_in};
        f = parity_bits(r);
        f[FLAG_C] = a[7];
      end
      OP_RR: begin
        r = {cmd.carry_in, a[7:1]};
        f = parity_bits(r);
        f[FLAG_C] = a[0];
      end
      OP_SLA: begin
        r = {a[6:0], 1'b0};
        f = parity_bits(r);
        f[FLAG_C] = a[7];
      end
      OP_SRA: begin
        r = {a[7], a[7:1]};
        f = parity_bits(r);
        f[FLAG_C] = a[0];
      end
      OP_SLL: begin
        r = {a[6:0], 1'b1};
        f = parity_bits(r);
        f[FLAG_C] = a[7];
      end
      OP_SRL: begin
        r = {1'b0, a[7:1]};
        f = parity_bits(r);
        f[FLAG_C] = a[0];
      end
      OP_DAA: begin
        lo   = a[3:0];
        corr = '0;
        cf   = cmd.carry_in;
        if (lo > DAA_LO_LIMIT || cmd.half_in) corr |= DAA_LO_CORR;
        if (a > DAA_HI_LIMIT || cmd.carry_in) begin
          corr |= DAA_HI_CORR;
          cf    = 1'b1;
        end
        if (cmd.subtract_in) begin
          r  = a - corr;
          hf = cmd.half_in && (lo <= DAA_LO_HALF);
        end else begin
          r  = a + corr;
          hf = (lo > DAA_LO_LIMIT);
        end
        f = parity_bits(r);
        f[FLAG_H] = hf;
        f[FLAG_N] = cmd.subtract_in;
        f[FLAG_C] = cf;
      end
      default: begin
        // Unused opcodes pass operand_a through with all flags clear.
        r = a;
        f = '0;
      end
    endcase
    res.result = r;
    res.flags  = f;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] random_byte();
    if ($urandom_range(0, 3) == 0) return CORNER_BYTES[$urandom_range(0, 7)];
    return 8'($urandom);
  endfunction

  // Mostly defined opcodes; about one in ten lands in the unused range.
  function automatic alu_in_t random_cmd();
    alu_in_t cmd;
    if ($urandom_range(0, 9) == 0)
      cmd.opcode = 5'($urandom_range(int'(OP_UNUSED_LO), int'(OP_UNUSED_HI)));
    else
      cmd.opcode = 5'($urandom_range(0, int'(OP_DAA)));
    cmd.operand_a   = random_byte();
    cmd.operand_b   = random_byte();
    cmd.carry_in    = 1'($urandom);
    cmd.half_in     = 1'($urandom);
    cmd.subtract_in = 1'($urandom);
    return cmd;
  endfunction

  task automatic add_row(logic [4:0] op, logic [7:0] a, logic [7:0] b,
                         logic c, logic h, logic n,
                         bit fixed = 1'b0, logic [15:0] want = '0);
    table_row_t row;
    row.cmd   = '{opcode: op, operand_a: a, operand_b: b,
                  carry_in: c, half_in: h, subtract_in: n};
    row.fixed = fixed;
    row.want  = want;
    stim_table.push_back(row);
  endtask

  // Drop start and put noise on the payload for a number of cycles.
  task automatic idle_for(int unsigned cycles);
    start_i          <= 1'b0;
    data_i           <= random_cmd();
    fixed_want_valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Work in bursts: when a burst runs out, idle for a random gap (maybe none).
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
      burst_left = $urandom_range(1, MAX_BURST);
      if (gap != 0) idle_for(gap);
    end
    burst_left--;
  endtask

  // Present one command and hold it until the block takes it.
  task automatic send_cmd(alu_in_t cmd, bit fixed, alu_out_t want);
    start_i          <= 1'b1;
    data_i           <= cmd;
    fixed_want_valid <= fixed;
    fixed_want       <= want;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Hold off the sender until every outstanding result has been transferred.
  task automatic drain_results();
    start_i          <= 1'b0;
    fixed_want_valid <= 1'b0;
    do @(negedge clk_i); while (pending_alu_q.size() != 0);
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard and watchdog: sample at the edge that ends each cycle
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    alu_out_t want;
    if (rst_ni) begin
      // Check results before recording new commands; a command can never
      // produce its result at the same edge that takes it.
      if (done_o) begin
        if (pending_alu_q.size() == 0) begin
          $error("unexpected result: result %02h flags %02h", data_o.result, data_o.flags);
          mismatch_cnt++;
        end else begin
          want = pending_alu_q.pop_front();
          if (data_o.result !== want.result) begin
            $error("result: expected %02h, actual %02h", want.result, data_o.result);
            mismatch_cnt++;
          end
          if (data_o.flags !== want.flags) begin
            $error("flags: expected %02h, actual %02h", want.flags, data_o.flags);
            mismatch_cnt++;
          end
        end
      end
      if (start_i && !busy_o)
        pending_alu_q.push_back(fixed_want_valid ? fixed_want : predict_alu_out(data_i));

      // Any transfer in either direction resets the stall counter.
      if (done_o || (start_i && !busy_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_eight_bit_alu_flag_unit: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Directed table. Rows with a typed expectation are the ones that can be
    // read straight off the flag rules; the rest go through the predictor.
    add_row(OP_ADD, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 16'h00_40);  // zero sum
    add_row(OP_ADD, 8'hFF, 8'h01, 1'b0, 1'b0, 1'b0, 1'b1, 16'h00_51);  // wrap to zero
    add_row(OP_ADC, 8'h7F, 8'h00, 1'b1, 1'b0, 1'b0);                   // overflow via carry
    add_row(OP_SUB, 8'h00, 8'h01, 1'b0, 1'b0, 1'b0);                   // borrow out
    add_row(OP_SBC, 8'h80, 8'h7F, 1'b1, 1'b0, 1'b0);                   // signed overflow
    add_row(OP_AND, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b1, 16'hFF_BC);
    add_row(OP_XOR, 8'h5A, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b1, 16'h00_44);
    add_row(OP_OR,  8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 16'h00_44);
    add_row(OP_CP,  8'h10, 8'h28, 1'b0, 1'b0, 1'b0);   // bits 5 and 3 from operand_b
    add_row(OP_CP,  8'h42, 8'h42, 1'b1, 1'b0, 1'b0);   // equal, zero set
    add_row(OP_INC, 8'h7F, 8'h00, 1'b1, 1'b0, 1'b0);   // overflow, carry stays clear
    add_row(OP_INC, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 16'h00_50);
    add_row(OP_DEC, 8'h80, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(OP_DEC, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 16'hFF_BA);
    add_row(OP_RLC, 8'h80, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(OP_RRC, 8'h01, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(OP_RL,  8'h80, 8'h00, 1'b1, 1'b0, 1'b0);
    add_row(OP_RR,  8'h01, 8'h00, 1'b1, 1'b0, 1'b0);
    add_row(OP_SLA, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(OP_SRA, 8'h80, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(OP_SLL, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(OP_SRL, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(OP_DAA, 8'h9A, 8'h00, 1'b0, 1'b0, 1'b0);   // both corrections after add
    add_row(OP_DAA, 8'h06, 8'h00, 1'b1, 1'b1, 1'b1);   // subtract with half and carry
    add_row(OP_UNUSED_HI, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFF_00);
    add_row(OP_UNUSED_LO, 8'hA5, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b1, 16'hA5_00);

    // Hold reset for a few cycles, then release it once for the whole run.
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      pace();
      send_cmd(stim_table[i].cmd, stim_table[i].fixed, stim_table[i].want);
    end
    drain_results();

    // Random commands in bursts; pause halfway until the pipe is empty.
    for (int i = 0; i < ITEM_COUNT; i++) begin
      if (i == ITEM_COUNT / 2) drain_results();
      pace();
      send_cmd(random_cmd(), 1'b0, '0);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_alu_q.size() == 0) begin
      $display("tb_eight_bit_alu_flag_unit: PASS");
    end else begin
      $display("tb_eight_bit_alu_flag_unit: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/z80alu_pkg.sv
design/z80alu_core.sv
design/eight_bit_alu_flag_unit.sv
tb/tb_eight_bit_alu_flag_unit.sv
